FILE: sv/sfs_pkg.sv
// Shared types, constants and arithmetic helpers for the sampled file signature block.
package sfs_pkg;

   localparam int WINDOW_BYTES_DEF = 64;
   localparam int SAMPLE_CAP_DEF   = 64;
   localparam int SIZE_BITS_DEF    = 48;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_START  = 3'd0;
   localparam logic [2:0] KIND_PATH   = 3'd1;
   localparam logic [2:0] KIND_POS    = 3'd2;
   localparam logic [2:0] KIND_DATA   = 3'd3;
   localparam logic [2:0] KIND_FINISH = 3'd4;

   localparam logic [1:0] ANS_COUNT = 2'd0;
   localparam logic [1:0] ANS_POS   = 2'd1;
   localparam logic [1:0] ANS_SIG   = 2'd2;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] ROT_INIT  = 64'h9e3779b97f4a7c15;
   localparam logic [31:0] SEED_MIX  = 32'h9e3779b9;
   localparam logic [31:0] LCG_MULT  = 32'd1103515245;
   localparam logic [31:0] LCG_INC   = 32'd12345;
   localparam logic [5:0]  WCOUNT_LAST = 6'd62;

   typedef struct packed {
      logic [2:0]  kind;
      logic [47:0] file_size;
      logic [7:0]  path_byte;
      logic [7:0]  data_byte;
      logic        window_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  answer_kind;
      logic        status;
      logic [6:0]  sample_count;
      logic [47:0] window_offset;
      logic [6:0]  window_length;
      logic [63:0] sig_xor;
      logic [63:0] sig_rot;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [47:0] size;
      logic [7:0]  byte_val;
      logic        wend;
      logic [6:0]  count;
      logic        tiny;
   } entry_type;

   typedef struct packed {
      logic [2:0] op;
      logic       status;
      logic       calc;
      logic [6:0] count;
      logic [6:0] length;
      logic       tiny;
      logic       wend;
   } ctrl_type;

   // The FNV-1a 64 prime is 2^40 + 435, so the product is a sum of shifted copies.
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // Since 4096 leaves 1 modulo 65 and 64 leaves -1, the remainder comes from narrow folds.
   function automatic logic [6:0] mod65(input logic [31:0] x);
      logic [13:0] s;
      logic [12:0] t;
      logic [6:0]  a;
      logic [6:0]  b;
      s = 14'(x[11:0]) + 14'(x[23:12]) + 14'(x[31:24]);
      t = 13'(s[11:0]) + 13'(s[13:12]);
      a = t[12:6];
      b = {1'b0, t[5:0]};
      if (b >= a) begin
         return b - a;
      end else begin
         return 7'(8'(b) + 8'd65 - 8'(a));
      end
   endfunction

   function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] n);
      logic [127:0] d;
      d = {v, v} << n;
      return d[127:64];
   endfunction

endpackage

FILE: sv/sfs_front.sv
// Input stage that accepts transactions, drops unknown kinds and works out the sample count.
module sfs_front import sfs_pkg::*; #(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int SAMPLE_CAP   = SAMPLE_CAP_DEF,
   parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   input  logic [QLVL_BITS-1:0] q_level,
   output logic                 push,
   output entry_type            push_entry
);

   logic                 f_valid_ff, f_valid_in;
   entry_type            f_entry_ff, f_entry_in;
   logic                 accept;
   logic                 known;
   logic [SIZE_BITS-1:0] size;
   logic                 tiny;
   logic [SAMPLE_CAP+1:1] ge;
   logic [6:0]           count;

   assign req_stall = ({1'b0, q_level} + (QLVL_BITS+1)'(f_valid_ff))
                      >= (QLVL_BITS+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign size      = SIZE_BITS'(req_data.file_size);
   assign tiny      = size <= SIZE_BITS'(WINDOW_BYTES);

   always_comb begin
      unique case (req_data.kind) inside
         KIND_START, KIND_PATH, KIND_POS, KIND_DATA, KIND_FINISH: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   // The sample count is the highest k for which the size holds WINDOW_BYTES << k bytes.
   always_comb begin
      ge[SAMPLE_CAP+1] = 1'b0;
      for (int k = 1; k <= SAMPLE_CAP; k++) begin
         ge[k] = (size >> k) >= SIZE_BITS'(WINDOW_BYTES);
      end
      count = '0;
      for (int k = 1; k <= SAMPLE_CAP; k++) begin
         if (ge[k] && !ge[k+1]) begin
            count = count | 7'(k);
         end
      end
      if (count == 7'd0 || tiny) begin
         count = 7'd1;
      end
   end

   always_comb begin
      f_valid_in = accept && known;
      f_entry_in = f_entry_ff;
      if (accept) begin
         f_entry_in.op       = req_data.kind;
         f_entry_in.size     = 48'(size);
         f_entry_in.byte_val = (req_data.kind == KIND_PATH) ? req_data.path_byte
                                                            : req_data.data_byte;
         f_entry_in.wend     = req_data.window_end;
         f_entry_in.count    = count;
         f_entry_in.tiny     = tiny;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      f_entry_ff <= f_entry_in;
   end

   assign push       = f_valid_ff;
   assign push_entry = f_entry_ff;

endmodule

FILE: sv/sfs_queue.sv
// Short queue that decouples the input stage from the execution stages.
module sfs_queue import sfs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  entry_type            push_entry,
   input  logic                 pop,
   output logic                 pop_valid,
   output entry_type            pop_entry,
   output logic [QLVL_BITS-1:0] level
);

   entry_type            entries_ff [QUEUE_DEPTH];
   entry_type            entries_in [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_BITS-1:0] level_ff, level_in;

   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_entry;
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      level_in = level_ff + QLVL_BITS'(push) - QLVL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      entries_ff <= entries_in;
   end

   assign pop_valid = level_ff != '0;
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign level     = level_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (level_ff < QLVL_BITS'(QUEUE_DEPTH) || pop))
      else $error("Queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> level_ff != '0)
      else $error("Queue read while empty.");

endmodule

FILE: sv/sfs_core.sv
// Execution stage that holds the seed, hash and sampling state and updates it per transaction.
module sfs_core import sfs_pkg::*; #(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  entry_type            q_entry,
   output logic                 q_pop,
   input  logic                 take,
   output logic                 s1_valid,
   output ctrl_type             s1_ctrl,
   output logic [31:0]          s1_seed,
   output logic [SIZE_BITS-1:0] s1_base,
   output logic [SIZE_BITS-1:0] s1_limit,
   output logic [63:0]          s1_hash,
   output logic [5:0]           s1_rot
);

   logic [31:0]          seed_ff, seed_in;
   logic [63:0]          fnv_ff, fnv_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [6:0]           total_ff, total_in;
   logic [6:0]           index_ff, index_in;
   logic [5:0]           wcount_ff, wcount_in;
   logic                 tiny_ff, tiny_in;

   logic                 s1_valid_ff, s1_valid_in;
   ctrl_type             s1_ctrl_ff, s1_ctrl_in;
   logic [31:0]          s1_seed_ff, s1_seed_in;
   logic [SIZE_BITS-1:0] s1_base_ff, s1_base_in;
   logic [SIZE_BITS-1:0] s1_limit_ff, s1_limit_in;
   logic [63:0]          s1_hash_ff, s1_hash_in;
   logic [5:0]           s1_rot_ff, s1_rot_in;

   logic                 pop;
   logic [31:0]          lcg;
   logic [63:0]          fnv_next;
   logic [5:0]           wc_next;

   assign pop      = q_valid && (!s1_valid_ff || take);
   assign lcg      = 32'(seed_ff * LCG_MULT) + LCG_INC;
   assign fnv_next = fnv_step(fnv_ff, q_entry.byte_val);
   assign wc_next  = (wcount_ff == WCOUNT_LAST) ? 6'd0 : wcount_ff + 6'd1;

   always_comb begin
      seed_in     = seed_ff;
      fnv_in      = fnv_ff;
      size_in     = size_ff;
      total_in    = total_ff;
      index_in    = index_ff;
      wcount_in   = wcount_ff;
      tiny_in     = tiny_ff;
      s1_ctrl_in  = s1_ctrl_ff;
      s1_seed_in  = s1_seed_ff;
      s1_base_in  = s1_base_ff;
      s1_limit_in = s1_limit_ff;
      s1_hash_in  = s1_hash_ff;
      s1_rot_in   = s1_rot_ff;
      s1_valid_in = pop ? 1'b1 : (take ? 1'b0 : s1_valid_ff);
      if (pop) begin
         s1_ctrl_in    = '0;
         s1_ctrl_in.op = q_entry.op;
         s1_seed_in    = lcg;
         s1_base_in    = size_ff - (size_ff >> index_ff);
         s1_limit_in   = size_ff - SIZE_BITS'(WINDOW_BYTES);
         s1_hash_in    = fnv_next;
         s1_rot_in     = wc_next;
         unique case (q_entry.op)
            KIND_START: begin
               size_in   = SIZE_BITS'(q_entry.size);
               seed_in   = 32'(q_entry.size) ^ SEED_MIX;
               tiny_in   = q_entry.tiny;
               total_in  = q_entry.count;
               index_in  = 7'd1;
               wcount_in = 6'd0;
               fnv_in    = FNV_BASIS;
               s1_ctrl_in.count  = q_entry.count;
               s1_ctrl_in.tiny   = q_entry.tiny;
               s1_ctrl_in.length = q_entry.tiny ? 7'(q_entry.size) : 7'(WINDOW_BYTES);
            end
            KIND_PATH: begin
               seed_in = (seed_ff << 5) - seed_ff + {24'd0, q_entry.byte_val};
            end
            KIND_POS: begin
               if (index_ff > total_ff) begin
                  s1_ctrl_in.status = 1'b1;
               end else begin
                  index_in = index_ff + 7'd1;
                  if (tiny_ff) begin
                     s1_ctrl_in.length = 7'(size_ff);
                  end else begin
                     seed_in           = lcg;
                     s1_ctrl_in.calc   = 1'b1;
                     s1_ctrl_in.length = 7'(WINDOW_BYTES);
                  end
               end
            end
            KIND_DATA: begin
               s1_ctrl_in.tiny = tiny_ff;
               s1_ctrl_in.wend = q_entry.wend;
               if (q_entry.wend) begin
                  fnv_in    = FNV_BASIS;
                  wcount_in = 6'd0;
               end else begin
                  fnv_in    = fnv_next;
                  wcount_in = wc_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= '0;
         fnv_ff      <= FNV_BASIS;
         size_ff     <= '0;
         total_ff    <= '0;
         index_ff    <= 7'd1;
         wcount_ff   <= '0;
         tiny_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         seed_ff     <= seed_in;
         fnv_ff      <= fnv_in;
         size_ff     <= size_in;
         total_ff    <= total_in;
         index_ff    <= index_in;
         wcount_ff   <= wcount_in;
         tiny_ff     <= tiny_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_ctrl_ff  <= s1_ctrl_in;
      s1_seed_ff  <= s1_seed_in;
      s1_base_ff  <= s1_base_in;
      s1_limit_ff <= s1_limit_in;
      s1_hash_ff  <= s1_hash_in;
      s1_rot_ff   <= s1_rot_in;
   end

   assign q_pop    = pop;
   assign s1_valid = s1_valid_ff;
   assign s1_ctrl  = s1_ctrl_ff;
   assign s1_seed  = s1_seed_ff;
   assign s1_base  = s1_base_ff;
   assign s1_limit = s1_limit_ff;
   assign s1_hash  = s1_hash_ff;
   assign s1_rot   = s1_rot_ff;

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, index_ff} <= {1'b0, total_ff} + 8'd1)
      else $error("Sample index ran past the sample total.");

   a_wcount_range: assert property (@(posedge clock) disable iff (reset)
      wcount_ff <= WCOUNT_LAST)
      else $error("Window byte count left its modulo range.");

endmodule

FILE: sv/sfs_finish.sv
// Completion stage that finishes window offsets, keeps the signature accumulators and holds the result.
module sfs_finish import sfs_pkg::*; #(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 s1_valid,
   input  ctrl_type             s1_ctrl,
   input  logic [31:0]          s1_seed,
   input  logic [SIZE_BITS-1:0] s1_base,
   input  logic [SIZE_BITS-1:0] s1_limit,
   input  logic [63:0]          s1_hash,
   input  logic [5:0]           s1_rot,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data
);

   logic [63:0]        acc_xor_ff, acc_xor_in;
   logic [63:0]        acc_rot_ff, acc_rot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               load;
   logic [6:0]         jump;
   logic [SIZE_BITS:0] sum;
   logic [SIZE_BITS-1:0] pos;
   logic [63:0]        rot_hash;
   rsp_type            res;
   logic               has_result;

   assign take     = !rsp_valid_ff || !rsp_stall;
   assign load     = s1_valid && take;
   assign jump     = mod65(s1_seed);
   assign sum      = {1'b0, s1_base} + (SIZE_BITS+1)'(jump);
   assign pos      = (sum > {1'b0, s1_limit}) ? s1_limit : sum[SIZE_BITS-1:0];
   assign rot_hash = rotl64(s1_hash, s1_rot);

   always_comb begin
      res        = '0;
      has_result = 1'b0;
      acc_xor_in = acc_xor_ff;
      acc_rot_in = acc_rot_ff;
      unique case (s1_ctrl.op)
         KIND_START: begin
            has_result        = 1'b1;
            res.answer_kind   = ANS_COUNT;
            res.sample_count  = s1_ctrl.count;
            res.window_length = s1_ctrl.length;
            if (s1_ctrl.tiny) begin
               acc_xor_in = FNV_BASIS;
               acc_rot_in = FNV_BASIS;
            end else begin
               acc_xor_in = '0;
               acc_rot_in = ROT_INIT;
            end
         end
         KIND_POS: begin
            has_result        = 1'b1;
            res.answer_kind   = ANS_POS;
            res.status        = s1_ctrl.status;
            res.window_offset = s1_ctrl.calc ? 48'(pos) : 48'd0;
            res.window_length = s1_ctrl.length;
         end
         KIND_DATA: begin
            if (s1_ctrl.wend) begin
               if (s1_ctrl.tiny) begin
                  acc_xor_in = s1_hash;
                  acc_rot_in = s1_hash;
               end else begin
                  acc_xor_in = acc_xor_ff ^ s1_hash;
                  acc_rot_in = acc_rot_ff + rot_hash;
               end
            end
         end
         KIND_FINISH: begin
            has_result      = 1'b1;
            res.answer_kind = ANS_SIG;
            res.sig_xor     = acc_xor_ff;
            res.sig_rot     = acc_rot_ff;
         end
         default: begin
         end
      endcase
      if (!load) begin
         acc_xor_in = acc_xor_ff;
         acc_rot_in = acc_rot_ff;
      end
      rsp_valid_in = take ? (load && has_result) : rsp_valid_ff;
      rsp_data_in  = (load && has_result) ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_xor_ff   <= '0;
         acc_rot_ff   <= ROT_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_xor_ff   <= acc_xor_in;
         acc_rot_ff   <= acc_rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_exhausted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.answer_kind == ANS_POS && rsp_data_ff.status)
      |-> (rsp_data_ff.window_offset == 48'd0 && rsp_data_ff.window_length == 7'd0))
      else $error("Refused position carries a nonzero offset or length.");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.answer_kind == ANS_COUNT)
      |-> rsp_data_ff.sample_count != 7'd0)
      else $error("Sample count result is zero.");

endmodule

FILE: sv/sampled_file_signature.sv
// Top level of the sampled file signature engine.
// The req channel carries one transaction per item: start (file size), path byte,
// window position request, data byte (with a window end flag) or finish. Unknown
// kinds are accepted and dropped. The rsp channel returns a sample count after a
// start, a window offset and length after a position request, and the two 64-bit
// signature halves after a finish; path and data bytes return nothing.
// Both channels use valid and stall; a transaction moves when valid is high and
// stall is low. Once taken, a request passes through the input stage register,
// the queue and the execution stage register to the completion stage result
// register, which drives rsp. One transaction per cycle is sustained while rsp
// is not stalled. While rsp is stalled, the result register holds and the
// four-entry queue keeps filling; req_stall rises once the queue and the input
// stage together hold four transactions.
// Reset is synchronous: it empties the pipeline and the queue and returns the seed,
// hash, sampling counters and accumulators to their initial values.
module sampled_file_signature import sfs_pkg::*; #(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int SAMPLE_CAP   = SAMPLE_CAP_DEF,
   parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                 push;
   entry_type            push_entry;
   logic                 q_pop;
   logic                 q_valid;
   entry_type            q_entry;
   logic [QLVL_BITS-1:0] q_level;
   logic                 take;
   logic                 s1_valid;
   ctrl_type             s1_ctrl;
   logic [31:0]          s1_seed;
   logic [SIZE_BITS-1:0] s1_base;
   logic [SIZE_BITS-1:0] s1_limit;
   logic [63:0]          s1_hash;
   logic [5:0]           s1_rot;

   sfs_front #(
      .WINDOW_BYTES(WINDOW_BYTES),
      .SAMPLE_CAP  (SAMPLE_CAP),
      .SIZE_BITS   (SIZE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_level    (q_level),
      .push       (push),
      .push_entry (push_entry)
   );

   sfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry),
      .level      (q_level)
   );

   sfs_core #(
      .WINDOW_BYTES(WINDOW_BYTES),
      .SIZE_BITS   (SIZE_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .take     (take),
      .s1_valid (s1_valid),
      .s1_ctrl  (s1_ctrl),
      .s1_seed  (s1_seed),
      .s1_base  (s1_base),
      .s1_limit (s1_limit),
      .s1_hash  (s1_hash),
      .s1_rot   (s1_rot)
   );

   sfs_finish #(
      .SIZE_BITS(SIZE_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_ctrl   (s1_ctrl),
      .s1_seed   (s1_seed),
      .s1_base   (s1_base),
      .s1_limit  (s1_limit),
      .s1_hash   (s1_hash),
      .s1_rot    (s1_rot),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sampled_file_signature_checker.sv
`timescale 1ns / 1ps
// Checker for the sampled file signature engine: predicts each answer and compares it.
module sampled_file_signature_checker import sfs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      answers_owed
);

   localparam int          WINDOW    = WINDOW_BYTES_DEF;
   localparam logic [63:0] HASH_MULT = 64'd1099511628211;
   localparam logic [31:0] PATH_MULT = 32'd31;
   localparam logic [63:0] JUMP_MOD  = 64'd65;

   logic [31:0] seed;
   logic [63:0] fnv;
   logic [63:0] acc_xor;
   logic [63:0] acc_rot;
   logic [47:0] file_len;
   logic [6:0]  samples_total;
   logic [6:0]  sample_next;
   logic [5:0]  win_bytes;
   logic        tiny;
   rsp_type     answers[$];

   function automatic logic [63:0] rotate_left(input logic [63:0] v, input int n);
      return (n == 0) ? v : ((v << n) | (v >> (64 - n)));
   endfunction

   function automatic logic [6:0] count_samples(input logic [47:0] len);
      logic [47:0] t;
      int n;
      t = len / 48'(WINDOW);
      n = 0;
      while (t > 1 && n < SAMPLE_CAP_DEF) begin
         t = t >> 1;
         n++;
      end
      if (n == 0 || len <= 48'(WINDOW)) begin
         n = 1;
      end
      return 7'(n);
   endfunction

   task automatic predict_answer(input req_type r);
      rsp_type a;
      logic [63:0] shifted;
      logic [63:0] limit;
      logic [63:0] pos;
      logic [63:0] h;
      a = '0;
      case (r.kind)
         KIND_START: begin
            file_len = r.file_size;
            seed = r.file_size[31:0] ^ SEED_MIX;
            tiny = (r.file_size <= 48'(WINDOW));
            samples_total = count_samples(r.file_size);
            sample_next = 7'd1;
            win_bytes = '0;
            fnv = FNV_BASIS;
            acc_xor = tiny ? FNV_BASIS : 64'd0;
            acc_rot = tiny ? FNV_BASIS : ROT_INIT;
            a.answer_kind = ANS_COUNT;
            a.sample_count = samples_total;
            a.window_length = tiny ? r.file_size[6:0] : 7'(WINDOW);
            answers.push_back(a);
         end
         KIND_PATH: begin
            seed = seed * PATH_MULT + {24'd0, r.path_byte};
         end
         KIND_POS: begin
            a.answer_kind = ANS_POS;
            if (sample_next > samples_total) begin
               a.status = 1'b1;
            end else begin
               if (tiny) begin
                  a.window_length = file_len[6:0];
               end else begin
                  seed = seed * LCG_MULT + LCG_INC;
                  shifted = (sample_next < 7'd64) ? (64'(file_len) >> sample_next) : 64'd0;
                  limit = 64'(file_len) - 64'(WINDOW);
                  pos = 64'(file_len) - shifted + (64'(seed) % JUMP_MOD);
                  if (pos > limit) begin
                     pos = limit;
                  end
                  a.window_offset = pos[47:0];
                  a.window_length = 7'(WINDOW);
               end
               sample_next = sample_next + 7'd1;
            end
            answers.push_back(a);
         end
         KIND_DATA: begin
            fnv = (fnv ^ {56'd0, r.data_byte}) * HASH_MULT;
            win_bytes = (win_bytes == WCOUNT_LAST) ? 6'd0 : win_bytes + 6'd1;
            if (r.window_end) begin
               h = fnv;
               if (tiny) begin
                  acc_xor = h;
                  acc_rot = h;
               end else begin
                  acc_xor = acc_xor ^ h;
                  acc_rot = acc_rot + rotate_left(h, int'(win_bytes));
               end
               fnv = FNV_BASIS;
               win_bytes = '0;
            end
         end
         KIND_FINISH: begin
            a.answer_kind = ANS_SIG;
            a.sig_xor = acc_xor;
            a.sig_rot = acc_rot;
            answers.push_back(a);
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         seed = '0;
         fnv = FNV_BASIS;
         acc_xor = '0;
         acc_rot = ROT_INIT;
         file_len = '0;
         samples_total = '0;
         sample_next = 7'd1;
         win_bytes = '0;
         tiny = 1'b0;
         answers.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               $display("%0t: result expected none got %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = answers.pop_front();
               check_field("answer_kind", 64'(want.answer_kind),
                           64'(rsp_data.answer_kind));
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("sample_count", 64'(want.sample_count),
                           64'(rsp_data.sample_count));
               check_field("window_offset", 64'(want.window_offset),
                           64'(rsp_data.window_offset));
               check_field("window_length", 64'(want.window_length),
                           64'(rsp_data.window_length));
               check_field("sig_xor", want.sig_xor, rsp_data.sig_xor);
               check_field("sig_rot", want.sig_rot, rsp_data.sig_rot);
            end
         end
         if (req_valid && !req_stall) begin
            predict_answer(req_data);
         end
      end
      answers_owed = answers.size();
   end

endmodule

FILE: tb/sampled_file_signature_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sampled file signature engine: clock, reset, stimulus and verdict.
module sampled_file_signature_tb;
   import sfs_pkg::*;

   localparam int         WINDOW        = WINDOW_BYTES_DEF;
   localparam int         WINDOW_LOG    = $clog2(WINDOW_BYTES_DEF);
   localparam int         COUNT_MAX     = SIZE_BITS_DEF - WINDOW_LOG - 1;
   localparam int         ITEM_GOAL     = 1000;
   localparam int         CALM_ITEMS    = 150;
   localparam int         HOLD_CYCLES   = 60;
   localparam int         SETTLE_CYCLES = 10;
   localparam int         TIME_LIMIT_NS = 1000000;
   localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
   localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      answers_owed;
   int      items_sent = 0;
   bit      calm = 1'b0;
   bit      hold_rsp = 1'b0;

   always #1 clock = ~clock;

   sampled_file_signature dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sampled_file_signature_checker sig_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .answers_owed (answers_owed)
   );

   function automatic req_type noise_item(input logic [2:0] kind);
      req_type r;
      r.kind = kind;
      r.file_size = {16'($urandom), $urandom};
      r.path_byte = 8'($urandom);
      r.data_byte = 8'($urandom);
      r.window_end = 1'($urandom);
      return r;
   endfunction

   function automatic logic [47:0] size_for_count(input int n);
      logic [47:0] base;
      base = 48'(1) << (n + WINDOW_LOG);
      return base | ({16'($urandom), $urandom} & (base - 48'd1));
   endfunction

   task automatic send_item(input req_type item);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (item.kind <= KIND_FINISH) begin
         items_sent++;
      end
   endtask

   task automatic send_start(input logic [47:0] len);
      req_type r;
      r = noise_item(KIND_START);
      r.file_size = len;
      send_item(r);
   endtask

   task automatic send_path(input logic [7:0] b);
      req_type r;
      r = noise_item(KIND_PATH);
      r.path_byte = b;
      send_item(r);
   endtask

   task automatic send_pos();
      send_item(noise_item(KIND_POS));
   endtask

   task automatic send_data(input logic [7:0] b, input logic last);
      req_type r;
      r = noise_item(KIND_DATA);
      r.data_byte = b;
      r.window_end = last;
      send_item(r);
   endtask

   task automatic send_finish();
      send_item(noise_item(KIND_FINISH));
   endtask

   task automatic send_window(input int len);
      bit broken;
      broken = ($urandom_range(0, 11) == 0);
      for (int k = 0; k < len; k++) begin
         send_data(8'($urandom), (k == len - 1) && !broken);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (answers_owed != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic wellformed_file(input logic [47:0] len, input int windows);
      int wlen;
      send_start(len);
      repeat ($urandom_range(0, 6)) send_path(8'($urandom));
      for (int w = 0; w < windows; w++) begin
         send_pos();
         if (len <= 48'(WINDOW)) begin
            wlen = int'(len);
         end else begin
            case ($urandom_range(0, 7))
               0, 1: wlen = WINDOW;
               2: wlen = WINDOW - 1;
               default: wlen = $urandom_range(1, 16);
            endcase
         end
         send_window(wlen);
      end
      if ($urandom_range(0, 4) == 0) begin
         send_pos();
      end
      send_finish();
   endtask

   task automatic position_sweep(input int n);
      send_start(size_for_count(n));
      repeat (n + 1) send_pos();
      send_window($urandom_range(1, 8));
      send_finish();
   endtask

   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #(TIME_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_pos();
      send_finish();
      send_data(8'h5a, 1'b1);
      send_item(noise_item(KIND_RESERVED_HI));
      send_start('0);
      send_pos();
      send_pos();
      send_finish();
      send_start(48'(WINDOW));
      send_path(8'h00);
      send_path(8'hff);
      send_pos();
      send_data(8'h00, 1'b0);
      send_data(8'hff, 1'b1);
      send_finish();
      send_start(48'(WINDOW + 1));
      send_path(8'h80);
      send_pos();
      send_data(8'hff, 1'b1);
      send_finish();
      send_start('1);
      send_pos();
      send_data(8'h01, 1'b1);
      send_finish();
      send_item(noise_item(KIND_RESERVED_LO));

      drain();
      hold_rsp = 1'b1;
      position_sweep(COUNT_MAX);

      while (items_sent < ITEM_GOAL) begin
         if (items_sent >= ITEM_GOAL - CALM_ITEMS) begin
            calm = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1: wellformed_file(48'($urandom_range(0, WINDOW)), 1);
            2, 3, 4, 5: begin
               n = $urandom_range(1, 3);
               if (n == 1 && $urandom_range(0, 2) == 0) begin
                  wellformed_file(48'($urandom_range(WINDOW + 1, 2 * WINDOW - 1)), 1);
               end else begin
                  wellformed_file(size_for_count(n), n);
               end
            end
            6: position_sweep($urandom_range(4, COUNT_MAX));
            default: begin
               repeat ($urandom_range(5, 20)) send_item(noise_item(3'($urandom)));
            end
         endcase
         if ($urandom_range(0, 19) == 0) begin
            drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
